### rtl/rbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rigid body Euler step package
// Word format, register codes and the shared fixed point helpers.
// ----------------------------------------------------------------------------
package rbe_pkg;

   localparam int FRAC_BITS = 16;
   localparam int WORD_W    = 32;
   localparam int PROD_W    = 64;
   localparam int DT_W      = 17;
   localparam int INV_W     = 31;
   localparam int MODE_W    = 2;
   localparam int CSR_IDX_W = 2;
   localparam int H_W       = 2 * DT_W - (FRAC_BITS + 1);

   localparam logic [MODE_W-1:0] MODE_EXPLICIT   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SYMPLECTIC = 2'd1;
   localparam logic [MODE_W-1:0] MODE_NEWTON     = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY   = 2'd2;

   localparam logic [MODE_W-1:0]        MODE_RESET = MODE_EXPLICIT;
   localparam logic [DT_W-1:0]          DT_RESET   = 17'd1092;
   localparam logic signed [WORD_W-1:0] GRAV_RESET = -32'sd642253;

   localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic signed [PROD_W-1:0] prod_type;

   // state after the acceleration stages
   typedef struct packed {
      logic     is_static;
      word_type px;
      word_type py;
      word_type vx;
      word_type vy;
      word_type ang;
      word_type spin;
      word_type ax;
      word_type ay;
      word_type alpha;
      word_type dpx;
      word_type dpy;
      word_type dang;
   } accel_type;

   // state after the velocity stages
   typedef struct packed {
      logic     is_static;
      word_type px;
      word_type py;
      word_type ang;
      word_type vx;
      word_type vy;
      word_type spin;
      word_type dpx;
      word_type dpy;
      word_type dang;
   } vel_type;

   // floor(p / 2^FRAC_BITS), saturated to the word
   function automatic word_type q_scale(input prod_type p);
      logic signed [PROD_W-FRAC_BITS-1:0] s;
      logic [PROD_W-FRAC_BITS-WORD_W:0]   top;
      s   = p[PROD_W-1:FRAC_BITS];
      top = s[PROD_W-FRAC_BITS-1:WORD_W-1];
      if (&top || ~|top) begin
         return s[WORD_W-1:0];
      end
      return s[PROD_W-FRAC_BITS-1] ? WORD_MIN : WORD_MAX;
   endfunction

   function automatic word_type sat_add(input word_type a, input word_type b);
      logic signed [WORD_W:0] s;
      s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
      if (s[WORD_W] != s[WORD_W-1]) begin
         return s[WORD_W] ? WORD_MIN : WORD_MAX;
      end
      return s[WORD_W-1:0];
   endfunction

endpackage

### rtl/rbe_accel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rigid body Euler step: acceleration stages
// Forms force and torque accelerations and the old-rate deltas over two
// register stages.
// ----------------------------------------------------------------------------
module rbe_accel (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           take,
   input  logic signed [rbe_pkg::WORD_W-1:0] pos_x,
   input  logic signed [rbe_pkg::WORD_W-1:0] pos_y,
   input  logic signed [rbe_pkg::WORD_W-1:0] vel_x,
   input  logic signed [rbe_pkg::WORD_W-1:0] vel_y,
   input  logic signed [rbe_pkg::WORD_W-1:0] ang,
   input  logic signed [rbe_pkg::WORD_W-1:0] spin,
   input  logic signed [rbe_pkg::WORD_W-1:0] frc_x,
   input  logic signed [rbe_pkg::WORD_W-1:0] frc_y,
   input  logic signed [rbe_pkg::WORD_W-1:0] torque,
   input  logic [rbe_pkg::INV_W-1:0]      inv_mass,
   input  logic [rbe_pkg::INV_W-1:0]      inv_inertia,
   input  logic [rbe_pkg::DT_W-1:0]       dt,
   output logic                           acc_valid_o,
   output rbe_pkg::accel_type             acc_o
);

   logic                  vld1_ff, vld2_ff;
   logic                  stat1_ff;
   rbe_pkg::word_type     px1_ff, py1_ff, vx1_ff, vy1_ff, ang1_ff, spin1_ff;
   rbe_pkg::prod_type     pax_ff, pay_ff, pal_ff, pdx_ff, pdy_ff, pda_ff;
   rbe_pkg::accel_type    acc_ff, acc_in;
   logic signed [rbe_pkg::WORD_W-1:0] im_s, ii_s;
   logic signed [rbe_pkg::DT_W:0]     dt_s;

   assign im_s = $signed({1'b0, inv_mass});
   assign ii_s = $signed({1'b0, inv_inertia});
   assign dt_s = $signed({1'b0, dt});

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else begin
         vld1_ff <= take;
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      stat1_ff <= (inv_mass == '0);
      px1_ff   <= pos_x;
      py1_ff   <= pos_y;
      vx1_ff   <= vel_x;
      vy1_ff   <= vel_y;
      ang1_ff  <= ang;
      spin1_ff <= spin;
      pax_ff   <= frc_x * im_s;
      pay_ff   <= frc_y * im_s;
      pal_ff   <= torque * ii_s;
      pdx_ff   <= vel_x * dt_s;
      pdy_ff   <= vel_y * dt_s;
      pda_ff   <= spin * dt_s;
      acc_ff   <= acc_in;
   end

   always_comb begin
      acc_in.is_static = stat1_ff;
      acc_in.px        = px1_ff;
      acc_in.py        = py1_ff;
      acc_in.vx        = vx1_ff;
      acc_in.vy        = vy1_ff;
      acc_in.ang       = ang1_ff;
      acc_in.spin      = spin1_ff;
      acc_in.ax        = rbe_pkg::q_scale(pax_ff);
      acc_in.ay        = rbe_pkg::q_scale(pay_ff);
      acc_in.alpha     = rbe_pkg::q_scale(pal_ff);
      acc_in.dpx       = rbe_pkg::q_scale(pdx_ff);
      acc_in.dpy       = rbe_pkg::q_scale(pdy_ff);
      acc_in.dang      = rbe_pkg::q_scale(pda_ff);
   end

   assign acc_valid_o = vld2_ff;
   assign acc_o       = acc_ff;

endmodule

### rtl/rbe_vel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rigid body Euler step: velocity stages
// Integrates linear and angular velocity over two register stages.
// ----------------------------------------------------------------------------
module rbe_vel (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     acc_valid,
   input  rbe_pkg::accel_type       acc,
   input  logic [rbe_pkg::DT_W-1:0] dt,
   input  rbe_pkg::word_type        grav_dt,
   output logic                     vel_valid_o,
   output rbe_pkg::vel_type         vel_o
);

   logic                  vld3_ff, vld4_ff;
   rbe_pkg::accel_type    acc3_ff;
   rbe_pkg::prod_type     pvx_ff, pvy_ff, psp_ff;
   rbe_pkg::vel_type      vel_ff, vel_in;
   logic signed [rbe_pkg::DT_W:0] dt_s;

   assign dt_s = $signed({1'b0, dt});

   always_ff @(posedge clock) begin
      if (reset) begin
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
      end else begin
         vld3_ff <= acc_valid;
         vld4_ff <= vld3_ff;
      end
   end

   always_ff @(posedge clock) begin
      acc3_ff <= acc;
      pvx_ff  <= acc.ax * dt_s;
      pvy_ff  <= acc.ay * dt_s;
      psp_ff  <= acc.alpha * dt_s;
      vel_ff  <= vel_in;
   end

   always_comb begin
      vel_in.is_static = acc3_ff.is_static;
      vel_in.px        = acc3_ff.px;
      vel_in.py        = acc3_ff.py;
      vel_in.ang       = acc3_ff.ang;
      vel_in.dpx       = acc3_ff.dpx;
      vel_in.dpy       = acc3_ff.dpy;
      vel_in.dang      = acc3_ff.dang;
      if (acc3_ff.is_static) begin
         vel_in.vx   = acc3_ff.vx;
         vel_in.vy   = acc3_ff.vy;
         vel_in.spin = acc3_ff.spin;
      end else begin
         vel_in.vx   = rbe_pkg::sat_add(acc3_ff.vx, rbe_pkg::q_scale(pvx_ff));
         vel_in.vy   = rbe_pkg::sat_add(
                          rbe_pkg::sat_add(acc3_ff.vy, rbe_pkg::q_scale(pvy_ff)), grav_dt);
         vel_in.spin = rbe_pkg::sat_add(acc3_ff.spin, rbe_pkg::q_scale(psp_ff));
      end
   end

   assign vel_valid_o = vld4_ff;
   assign vel_o       = vel_ff;

endmodule

### rtl/rbe_pos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rigid body Euler step: position stages
// Integrates position and angle by the selected rule and drives the result
// registers.
// ----------------------------------------------------------------------------
module rbe_pos (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       vel_valid,
   input  rbe_pkg::vel_type           vel,
   input  logic [rbe_pkg::DT_W-1:0]   dt,
   input  logic [rbe_pkg::MODE_W-1:0] mode,
   input  rbe_pkg::word_type          grav_h,
   output logic                       out_strobe,
   output rbe_pkg::word_type          out_pos_x,
   output rbe_pkg::word_type          out_pos_y,
   output rbe_pkg::word_type          out_vel_x,
   output rbe_pkg::word_type          out_vel_y,
   output rbe_pkg::word_type          out_ang,
   output rbe_pkg::word_type          out_spin,
   output logic                       out_static
);

   logic                  vld5_ff, vld6_ff;
   rbe_pkg::vel_type      vel5_ff;
   rbe_pkg::prod_type     ppx_ff, ppy_ff, pan_ff;
   rbe_pkg::word_type     px_in, py_in, ang_in, dpx, dpy, dang;
   rbe_pkg::word_type     px_ff, py_ff, vx_ff, vy_ff, ang_ff, spin_ff;
   logic                  stat_ff;
   logic signed [rbe_pkg::DT_W:0] dt_s;

   assign dt_s = $signed({1'b0, dt});

   always_ff @(posedge clock) begin
      if (reset) begin
         vld5_ff <= 1'b0;
         vld6_ff <= 1'b0;
      end else begin
         vld5_ff <= vel_valid;
         vld6_ff <= vld5_ff;
      end
   end

   always_ff @(posedge clock) begin
      vel5_ff <= vel;
      ppx_ff  <= vel.vx * dt_s;
      ppy_ff  <= vel.vy * dt_s;
      pan_ff  <= vel.spin * dt_s;
      px_ff   <= px_in;
      py_ff   <= py_in;
      vx_ff   <= vel5_ff.vx;
      vy_ff   <= vel5_ff.vy;
      ang_ff  <= ang_in;
      spin_ff <= vel5_ff.spin;
      stat_ff <= vel5_ff.is_static;
   end

   always_comb begin
      case (mode)
         rbe_pkg::MODE_SYMPLECTIC: begin
            dpx  = rbe_pkg::q_scale(ppx_ff);
            dpy  = rbe_pkg::q_scale(ppy_ff);
            dang = rbe_pkg::q_scale(pan_ff);
         end
         rbe_pkg::MODE_NEWTON: begin
            dpx  = vel5_ff.dpx;
            dpy  = rbe_pkg::sat_add(vel5_ff.dpy, grav_h);
            dang = vel5_ff.dang;
         end
         default: begin
            dpx  = vel5_ff.dpx;
            dpy  = vel5_ff.dpy;
            dang = vel5_ff.dang;
         end
      endcase
      if (vel5_ff.is_static) begin
         px_in  = vel5_ff.px;
         py_in  = vel5_ff.py;
         ang_in = vel5_ff.ang;
      end else begin
         px_in  = rbe_pkg::sat_add(vel5_ff.px, dpx);
         py_in  = rbe_pkg::sat_add(vel5_ff.py, dpy);
         ang_in = rbe_pkg::sat_add(vel5_ff.ang, dang);
      end
   end

   assign out_strobe = vld6_ff;
   assign out_pos_x  = px_ff;
   assign out_pos_y  = py_ff;
   assign out_vel_x  = vx_ff;
   assign out_vel_y  = vy_ff;
   assign out_ang    = ang_ff;
   assign out_spin   = spin_ff;
   assign out_static = stat_ff;

endmodule

### rtl/rigid_body_euler_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rigid body Euler step
// One 2D rigid body state per transaction advanced by one time step,
// signed Q16.16 with saturation.
// ----------------------------------------------------------------------------
// One transaction is taken every cycle (busy is always low) and its result
// appears on the rsp_ ports after the six register stages, for one cycle,
// flagged by rsp_strobe; the pipeline never stalls, so the receiver must take
// every result. Each of the six stages holds either one set of multiplies or
// the scaling and saturating adds behind them. Register writes are taken at
// once, but the gravity terms derived from them settle in later registers.
module rigid_body_euler_step (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [31:0]                req_position_x,
   input  logic signed [31:0]                req_position_y,
   input  logic signed [31:0]                req_velocity_x,
   input  logic signed [31:0]                req_velocity_y,
   input  logic signed [31:0]                req_angle,
   input  logic signed [31:0]                req_spin_rate,
   input  logic signed [31:0]                req_force_x,
   input  logic signed [31:0]                req_force_y,
   input  logic signed [31:0]                req_torque_in,
   input  logic [30:0]                       req_inverse_mass,
   input  logic [30:0]                       req_inverse_inertia,
   output logic                              rsp_strobe,
   output logic signed [31:0]                rsp_new_position_x,
   output logic signed [31:0]                rsp_new_position_y,
   output logic signed [31:0]                rsp_new_velocity_x,
   output logic signed [31:0]                rsp_new_velocity_y,
   output logic signed [31:0]                rsp_new_angle,
   output logic signed [31:0]                rsp_new_spin_rate,
   output logic                              rsp_static_body,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rbe_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [31:0]                       csr_wdata
);

   logic [rbe_pkg::MODE_W-1:0] mode_ff;
   logic [rbe_pkg::DT_W-1:0]   dt_ff;
   rbe_pkg::word_type          grav_ff;
   logic [rbe_pkg::H_W-1:0]    h_ff;
   rbe_pkg::prod_type          dtg_prod_ff, hg_prod_ff;
   rbe_pkg::word_type          dtg_ff, hg_ff;
   logic [2*rbe_pkg::DT_W-1:0] dt_sq;
   logic                       take;
   logic                       csr_write;
   logic                       acc_valid, vel_valid;
   rbe_pkg::accel_type         acc;
   rbe_pkg::vel_type           vel;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign take      = start & ~busy;
   assign csr_write = csr_valid & csr_ready;
   assign dt_sq     = dt_ff * dt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= rbe_pkg::MODE_RESET;
         dt_ff   <= rbe_pkg::DT_RESET;
         grav_ff <= rbe_pkg::GRAV_RESET;
      end else if (csr_write) begin
         case (csr_index)
            rbe_pkg::CSR_MODE:      mode_ff <= csr_wdata[rbe_pkg::MODE_W-1:0];
            rbe_pkg::CSR_TIME_STEP: dt_ff   <= csr_wdata[rbe_pkg::DT_W-1:0];
            rbe_pkg::CSR_GRAVITY:   grav_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // gravity terms, fixed per register setting
   always_ff @(posedge clock) begin
      h_ff        <= dt_sq[2*rbe_pkg::DT_W-1:rbe_pkg::FRAC_BITS+1];
      dtg_prod_ff <= grav_ff * $signed({1'b0, dt_ff});
      hg_prod_ff  <= grav_ff * $signed({1'b0, h_ff});
      dtg_ff      <= rbe_pkg::q_scale(dtg_prod_ff);
      hg_ff       <= rbe_pkg::q_scale(hg_prod_ff);
   end

   rbe_accel u_accel (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .pos_x       (req_position_x),
      .pos_y       (req_position_y),
      .vel_x       (req_velocity_x),
      .vel_y       (req_velocity_y),
      .ang         (req_angle),
      .spin        (req_spin_rate),
      .frc_x       (req_force_x),
      .frc_y       (req_force_y),
      .torque      (req_torque_in),
      .inv_mass    (req_inverse_mass),
      .inv_inertia (req_inverse_inertia),
      .dt          (dt_ff),
      .acc_valid_o (acc_valid),
      .acc_o       (acc)
   );

   rbe_vel u_vel (
      .clock       (clock),
      .reset       (reset),
      .acc_valid   (acc_valid),
      .acc         (acc),
      .dt          (dt_ff),
      .grav_dt     (dtg_ff),
      .vel_valid_o (vel_valid),
      .vel_o       (vel)
   );

   rbe_pos u_pos (
      .clock      (clock),
      .reset      (reset),
      .vel_valid  (vel_valid),
      .vel        (vel),
      .dt         (dt_ff),
      .mode       (mode_ff),
      .grav_h     (hg_ff),
      .out_strobe (rsp_strobe),
      .out_pos_x  (rsp_new_position_x),
      .out_pos_y  (rsp_new_position_y),
      .out_vel_x  (rsp_new_velocity_x),
      .out_vel_y  (rsp_new_velocity_y),
      .out_ang    (rsp_new_angle),
      .out_spin   (rsp_new_spin_rate),
      .out_static (rsp_static_body)
   );

endmodule

### test/rbe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rigid body Euler step checker
// Watches the request, response and register channels, keeps its own copy of
// the step registers, predicts the updated body for every accepted
// transaction and compares each response with the oldest prediction.
// ----------------------------------------------------------------------------
module rbe_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  rbe_pkg::word_type             req_position_x,
   input  rbe_pkg::word_type             req_position_y,
   input  rbe_pkg::word_type             req_velocity_x,
   input  rbe_pkg::word_type             req_velocity_y,
   input  rbe_pkg::word_type             req_angle,
   input  rbe_pkg::word_type             req_spin_rate,
   input  rbe_pkg::word_type             req_force_x,
   input  rbe_pkg::word_type             req_force_y,
   input  rbe_pkg::word_type             req_torque_in,
   input  logic [rbe_pkg::INV_W-1:0]     req_inverse_mass,
   input  logic [rbe_pkg::INV_W-1:0]     req_inverse_inertia,
   input  logic                          rsp_strobe,
   input  rbe_pkg::word_type             rsp_new_position_x,
   input  rbe_pkg::word_type             rsp_new_position_y,
   input  rbe_pkg::word_type             rsp_new_velocity_x,
   input  rbe_pkg::word_type             rsp_new_velocity_y,
   input  rbe_pkg::word_type             rsp_new_angle,
   input  rbe_pkg::word_type             rsp_new_spin_rate,
   input  logic                          rsp_static_body,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [rbe_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_wdata,
   output int                            mismatch_count,
   output int                            results_outstanding
);

   localparam longint SAT_HI = 64'sd2147483647;
   localparam longint SAT_LO = -SAT_HI - 1;

   typedef struct packed {
      logic              is_static;
      rbe_pkg::word_type px;
      rbe_pkg::word_type py;
      rbe_pkg::word_type vx;
      rbe_pkg::word_type vy;
      rbe_pkg::word_type ang;
      rbe_pkg::word_type spin;
   } body_state_type;

   body_state_type             predicted_bodies[$];
   logic [rbe_pkg::MODE_W-1:0] cur_mode;
   logic [rbe_pkg::DT_W-1:0]   cur_dt;
   rbe_pkg::word_type          cur_grav;

   function automatic longint clamp_word(input longint x);
      if (x > SAT_HI) begin
         return SAT_HI;
      end
      if (x < SAT_LO) begin
         return SAT_LO;
      end
      return x;
   endfunction

   // exact product, floor to the fraction, saturate
   function automatic longint fix_mul(input longint a, input longint b);
      return clamp_word((a * b) >>> rbe_pkg::FRAC_BITS);
   endfunction

   function automatic body_state_type step_body(
      input rbe_pkg::word_type px_in, input rbe_pkg::word_type py_in,
      input rbe_pkg::word_type vx_in, input rbe_pkg::word_type vy_in,
      input rbe_pkg::word_type ang_in, input rbe_pkg::word_type spin_in,
      input rbe_pkg::word_type fx, input rbe_pkg::word_type fy,
      input rbe_pkg::word_type tq,
      input logic [rbe_pkg::INV_W-1:0] inv_m, input logic [rbe_pkg::INV_W-1:0] inv_i);
      longint         px, py, vx, vy, ang, spin;
      longint         ax, ay, alpha, dt, g, h;
      body_state_type r;
      if (inv_m == '0) begin
         r.is_static = 1'b1;
         r.px        = px_in;
         r.py        = py_in;
         r.vx        = vx_in;
         r.vy        = vy_in;
         r.ang       = ang_in;
         r.spin      = spin_in;
         return r;
      end
      px    = px_in;
      py    = py_in;
      vx    = vx_in;
      vy    = vy_in;
      ang   = ang_in;
      spin  = spin_in;
      dt    = cur_dt;
      g     = cur_grav;
      ax    = fix_mul(fx, inv_m);
      ay    = fix_mul(fy, inv_m);
      alpha = fix_mul(tq, inv_i);
      if (cur_mode == rbe_pkg::MODE_SYMPLECTIC) begin
         vx   = clamp_word(vx + fix_mul(dt, ax));
         vy   = clamp_word(vy + fix_mul(dt, ay));
         vy   = clamp_word(vy + fix_mul(dt, g));
         px   = clamp_word(px + fix_mul(dt, vx));
         py   = clamp_word(py + fix_mul(dt, vy));
         spin = clamp_word(spin + fix_mul(dt, alpha));
         ang  = clamp_word(ang + fix_mul(spin, dt));
      end else begin
         px = clamp_word(px + fix_mul(dt, vx));
         if (cur_mode == rbe_pkg::MODE_NEWTON) begin
            h  = (dt * dt) >>> (rbe_pkg::FRAC_BITS + 1);
            py = clamp_word(py + clamp_word(fix_mul(dt, vy) + fix_mul(h, g)));
         end else begin
            py = clamp_word(py + fix_mul(dt, vy));
         end
         vx   = clamp_word(vx + fix_mul(dt, ax));
         vy   = clamp_word(vy + fix_mul(dt, ay));
         vy   = clamp_word(vy + fix_mul(dt, g));
         ang  = clamp_word(ang + fix_mul(spin, dt));
         spin = clamp_word(spin + fix_mul(dt, alpha));
      end
      r.is_static = 1'b0;
      r.px        = px[rbe_pkg::WORD_W-1:0];
      r.py        = py[rbe_pkg::WORD_W-1:0];
      r.vx        = vx[rbe_pkg::WORD_W-1:0];
      r.vy        = vy[rbe_pkg::WORD_W-1:0];
      r.ang       = ang[rbe_pkg::WORD_W-1:0];
      r.spin      = spin[rbe_pkg::WORD_W-1:0];
      return r;
   endfunction

   function automatic int field_diff(input string name, input logic [31:0] want,
                                     input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      body_state_type want;
      int             errs;
      errs = 0;
      if (reset) begin
         cur_mode <= rbe_pkg::MODE_RESET;
         cur_dt   <= rbe_pkg::DT_RESET;
         cur_grav <= rbe_pkg::GRAV_RESET;
         predicted_bodies.delete();
         mismatch_count      <= 0;
         results_outstanding <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               rbe_pkg::CSR_MODE: begin
                  cur_mode <= csr_wdata[rbe_pkg::MODE_W-1:0];
               end
               rbe_pkg::CSR_TIME_STEP: begin
                  cur_dt <= csr_wdata[rbe_pkg::DT_W-1:0];
               end
               rbe_pkg::CSR_GRAVITY: begin
                  cur_grav <= csr_wdata;
               end
               default: begin
               end
            endcase
         end
         if (rsp_strobe) begin
            if (predicted_bodies.size() == 0) begin
               $display("%0t: response with no transaction outstanding, expected none actual %h",
                        $time, rsp_new_position_x);
               errs++;
            end else begin
               want = predicted_bodies.pop_front();
               errs += field_diff("new_position_x", want.px, rsp_new_position_x);
               errs += field_diff("new_position_y", want.py, rsp_new_position_y);
               errs += field_diff("new_velocity_x", want.vx, rsp_new_velocity_x);
               errs += field_diff("new_velocity_y", want.vy, rsp_new_velocity_y);
               errs += field_diff("new_angle", want.ang, rsp_new_angle);
               errs += field_diff("new_spin_rate", want.spin, rsp_new_spin_rate);
               errs += field_diff("static_body", want.is_static, rsp_static_body);
            end
         end
         if (start && !busy) begin
            predicted_bodies.push_back(step_body(
               req_position_x, req_position_y, req_velocity_x, req_velocity_y,
               req_angle, req_spin_rate, req_force_x, req_force_y, req_torque_in,
               req_inverse_mass, req_inverse_inertia));
         end
         mismatch_count      <= mismatch_count + errs;
         results_outstanding <= predicted_bodies.size();
      end
   end

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rigid body Euler step testbench
// Drives corner bodies under every step rule and register extreme, then
// random bodies over several register settings with varying sender gaps.
// The checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int DRAIN_LIMIT     = 1000;
   localparam int LATENCY_PAD     = 12;
   localparam int QUIET_CYCLES    = 8;
   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 244;
   localparam int NUM_CORNERS     = 6;

   localparam logic [rbe_pkg::MODE_W-1:0]    MODE_UNUSED = 2'd3;
   localparam logic [rbe_pkg::CSR_IDX_W-1:0] CSR_SPARE   = 2'd3;

   typedef struct packed {
      rbe_pkg::word_type         px;
      rbe_pkg::word_type         py;
      rbe_pkg::word_type         vx;
      rbe_pkg::word_type         vy;
      rbe_pkg::word_type         ang;
      rbe_pkg::word_type         spin;
      rbe_pkg::word_type         fx;
      rbe_pkg::word_type         fy;
      rbe_pkg::word_type         tq;
      logic [rbe_pkg::INV_W-1:0] inv_m;
      logic [rbe_pkg::INV_W-1:0] inv_i;
   } body_in_type;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   rbe_pkg::word_type             req_position_x;
   rbe_pkg::word_type             req_position_y;
   rbe_pkg::word_type             req_velocity_x;
   rbe_pkg::word_type             req_velocity_y;
   rbe_pkg::word_type             req_angle;
   rbe_pkg::word_type             req_spin_rate;
   rbe_pkg::word_type             req_force_x;
   rbe_pkg::word_type             req_force_y;
   rbe_pkg::word_type             req_torque_in;
   logic [rbe_pkg::INV_W-1:0]     req_inverse_mass;
   logic [rbe_pkg::INV_W-1:0]     req_inverse_inertia;
   logic                          rsp_strobe;
   rbe_pkg::word_type             rsp_new_position_x;
   rbe_pkg::word_type             rsp_new_position_y;
   rbe_pkg::word_type             rsp_new_velocity_x;
   rbe_pkg::word_type             rsp_new_velocity_y;
   rbe_pkg::word_type             rsp_new_angle;
   rbe_pkg::word_type             rsp_new_spin_rate;
   logic                          rsp_static_body;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [rbe_pkg::CSR_IDX_W-1:0] csr_index;
   logic [31:0]                   csr_wdata;
   int                            mismatch_count;
   int                            results_outstanding;
   int                            cycle_count = 0;

   body_in_type corner[NUM_CORNERS];
   int          phase_idle[4] = '{0, 55, 0, 23};

   rigid_body_euler_step i_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_position_x      (req_position_x),
      .req_position_y      (req_position_y),
      .req_velocity_x      (req_velocity_x),
      .req_velocity_y      (req_velocity_y),
      .req_angle           (req_angle),
      .req_spin_rate       (req_spin_rate),
      .req_force_x         (req_force_x),
      .req_force_y         (req_force_y),
      .req_torque_in       (req_torque_in),
      .req_inverse_mass    (req_inverse_mass),
      .req_inverse_inertia (req_inverse_inertia),
      .rsp_strobe          (rsp_strobe),
      .rsp_new_position_x  (rsp_new_position_x),
      .rsp_new_position_y  (rsp_new_position_y),
      .rsp_new_velocity_x  (rsp_new_velocity_x),
      .rsp_new_velocity_y  (rsp_new_velocity_y),
      .rsp_new_angle       (rsp_new_angle),
      .rsp_new_spin_rate   (rsp_new_spin_rate),
      .rsp_static_body     (rsp_static_body),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   rbe_checker i_checker (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_position_x      (req_position_x),
      .req_position_y      (req_position_y),
      .req_velocity_x      (req_velocity_x),
      .req_velocity_y      (req_velocity_y),
      .req_angle           (req_angle),
      .req_spin_rate       (req_spin_rate),
      .req_force_x         (req_force_x),
      .req_force_y         (req_force_y),
      .req_torque_in       (req_torque_in),
      .req_inverse_mass    (req_inverse_mass),
      .req_inverse_inertia (req_inverse_inertia),
      .rsp_strobe          (rsp_strobe),
      .rsp_new_position_x  (rsp_new_position_x),
      .rsp_new_position_y  (rsp_new_position_y),
      .rsp_new_velocity_x  (rsp_new_velocity_x),
      .rsp_new_velocity_y  (rsp_new_velocity_y),
      .rsp_new_angle       (rsp_new_angle),
      .rsp_new_spin_rate   (rsp_new_spin_rate),
      .rsp_static_body     (rsp_static_body),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .mismatch_count      (mismatch_count),
      .results_outstanding (results_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   function automatic rbe_pkg::word_type random_word();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: return rbe_pkg::WORD_MAX;
               1: return rbe_pkg::WORD_MIN;
               2: return '0;
               3: return -32'sd1;
               default: return 32'sd1;
            endcase
         end
         1, 2, 3: return $urandom;
         default: return int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      endcase
   endfunction

   function automatic logic [rbe_pkg::INV_W-1:0] random_inverse();
      logic [31:0] raw;
      logic [31:0] near;
      raw  = $urandom;
      near = $urandom_range(1, 32'h0004_0000);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return raw[rbe_pkg::INV_W-1:0];
         2: return '1;
         default: return near[rbe_pkg::INV_W-1:0];
      endcase
   endfunction

   function automatic body_in_type random_body();
      body_in_type b;
      b.px    = random_word();
      b.py    = random_word();
      b.vx    = random_word();
      b.vy    = random_word();
      b.ang   = random_word();
      b.spin  = random_word();
      b.fx    = random_word();
      b.fy    = random_word();
      b.tq    = random_word();
      b.inv_m = random_inverse();
      b.inv_i = random_inverse();
      return b;
   endfunction

   task automatic send_body(input body_in_type b, input int idle_pct);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start               <= 1'b1;
      req_position_x      <= b.px;
      req_position_y      <= b.py;
      req_velocity_x      <= b.vx;
      req_velocity_y      <= b.vy;
      req_angle           <= b.ang;
      req_spin_rate       <= b.spin;
      req_force_x         <= b.fx;
      req_force_y         <= b.fy;
      req_torque_in       <= b.tq;
      req_inverse_mass    <= b.inv_m;
      req_inverse_inertia <= b.inv_i;
      do @(posedge clock); while (busy);
   endtask

   task automatic write_csr(input logic [rbe_pkg::CSR_IDX_W-1:0] idx,
                            input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // unused upper data bits are filled at random
   task automatic configure(input logic [rbe_pkg::MODE_W-1:0] mode,
                            input logic [rbe_pkg::DT_W-1:0] dt,
                            input rbe_pkg::word_type grav);
      logic [31:0] data;
      start <= 1'b0;
      @(posedge clock);
      while (results_outstanding != 0) begin
         @(posedge clock);
      end
      data                      = $urandom;
      data[rbe_pkg::MODE_W-1:0] = mode;
      write_csr(rbe_pkg::CSR_MODE, data);
      data                      = $urandom;
      data[rbe_pkg::DT_W-1:0]   = dt;
      write_csr(rbe_pkg::CSR_TIME_STEP, data);
      write_csr(rbe_pkg::CSR_GRAVITY, grav);
      // derived gravity terms settle
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [rbe_pkg::MODE_W-1:0] mode;
      logic [rbe_pkg::DT_W-1:0]   dt;
      rbe_pkg::word_type          grav;
      logic [31:0]                pick;
      int                         waited;

      reset               = 1'b1;
      start               = 1'b0;
      req_position_x      = '0;
      req_position_y      = '0;
      req_velocity_x      = '0;
      req_velocity_y      = '0;
      req_angle           = '0;
      req_spin_rate       = '0;
      req_force_x         = '0;
      req_force_y         = '0;
      req_torque_in       = '0;
      req_inverse_mass    = '0;
      req_inverse_inertia = '0;
      csr_valid           = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;

      // zero body, static body, falling body, positive and negative
      // saturation, tiny negative products rounding down
      corner[0] = '{'0, '0, '0, '0, '0, '0, '0, '0, '0, 31'h0001_0000, 31'h0001_0000};
      corner[1] = '{rbe_pkg::WORD_MAX, rbe_pkg::WORD_MIN, -32'sd1, 32'sd1,
                    rbe_pkg::WORD_MIN, rbe_pkg::WORD_MAX, rbe_pkg::WORD_MAX,
                    rbe_pkg::WORD_MIN, rbe_pkg::WORD_MAX, '0, '1};
      corner[2] = '{'0, 32'sh000A_0000, 32'sh0002_0000, '0, 32'sh0000_8000,
                    32'sh0003_0000, '0, 32'sh0004_0000, -32'sh0001_0000,
                    31'h0000_8000, 31'h0002_0000};
      corner[3] = '{rbe_pkg::WORD_MAX, rbe_pkg::WORD_MAX, rbe_pkg::WORD_MAX,
                    rbe_pkg::WORD_MAX, rbe_pkg::WORD_MAX, rbe_pkg::WORD_MAX,
                    rbe_pkg::WORD_MAX, rbe_pkg::WORD_MAX, rbe_pkg::WORD_MAX, '1, '1};
      corner[4] = '{rbe_pkg::WORD_MIN, rbe_pkg::WORD_MIN, rbe_pkg::WORD_MIN,
                    rbe_pkg::WORD_MIN, rbe_pkg::WORD_MIN, rbe_pkg::WORD_MIN,
                    rbe_pkg::WORD_MIN, rbe_pkg::WORD_MIN, rbe_pkg::WORD_MIN, '1, '1};
      corner[5] = '{-32'sd1, 32'sd1, -32'sd3, -32'sd1, 32'sd1, -32'sd7,
                    -32'sd1, -32'sd1, -32'sd1, 31'd1, 31'd1};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < NUM_CORNERS; k++) begin
         send_body(corner[k], 0);
      end
      configure(rbe_pkg::MODE_SYMPLECTIC, 17'd65536, rbe_pkg::WORD_MIN);
      for (int k = 2; k < NUM_CORNERS; k++) begin
         send_body(corner[k], 0);
      end
      configure(rbe_pkg::MODE_NEWTON, 17'h1FFFF, rbe_pkg::WORD_MAX);
      for (int k = 2; k < NUM_CORNERS; k++) begin
         send_body(corner[k], 0);
      end
      configure(MODE_UNUSED, '0, 32'sh0001_0000);
      write_csr(CSR_SPARE, $urandom);
      for (int k = 0; k < NUM_CORNERS; k++) begin
         send_body(corner[k], 0);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         pick = $urandom_range(0, 3);
         mode = (p < 3) ? p[rbe_pkg::MODE_W-1:0] : pick[rbe_pkg::MODE_W-1:0];
         case ($urandom_range(0, 5))
            0: dt = $urandom_range(0, 1) ? '1 : '0;
            1: begin
               pick = $urandom_range(65537, 131071);
               dt   = pick[rbe_pkg::DT_W-1:0];
            end
            default: begin
               pick = $urandom_range(1, 65536);
               dt   = pick[rbe_pkg::DT_W-1:0];
            end
         endcase
         case ($urandom_range(0, 5))
            0: grav = $urandom;
            1: grav = $urandom_range(0, 1) ? rbe_pkg::WORD_MAX : rbe_pkg::WORD_MIN;
            default: grav = int'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
         endcase
         configure(mode, dt, grav);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_body(random_body(), phase_idle[p % 4]);
         end
      end

      start <= 1'b0;
      @(posedge clock);
      waited = 0;
      while (results_outstanding != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (LATENCY_PAD) @(posedge clock);
      if (mismatch_count == 0 && results_outstanding == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

### files.f
rtl/rbe_pkg.sv
rtl/rbe_accel.sv
rtl/rbe_vel.sv
rtl/rbe_pos.sv
rtl/rigid_body_euler_step.sv
test/rbe_checker.sv
test/tb.sv
